// File: sv/pct_pkg.sv
// Shared constants and types for the prefix-count trie.
package pct_pkg;

  localparam int NODE_COUNT  = 4096;
  localparam int SYMBOL_BITS = 8;
  localparam int COUNT_BITS  = 16;
  localparam int NODE_BITS   = $clog2(NODE_COUNT);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // One node record, minus its first-child link which lives in its own memory
  typedef struct packed {
    logic [SYMBOL_BITS-1:0] symbol;
    logic [NODE_BITS-1:0]   sibling;
    logic [COUNT_BITS-1:0]  pass_cnt;
    logic [COUNT_BITS-1:0]  end_cnt;
  } node_rec_t;

  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] addr;
    node_rec_t            data;
  } rec_wr_t;

  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] addr;
    logic [NODE_BITS-1:0] data;
  } link_wr_t;

endpackage

// File: sv/pct_node_store.sv
// Node pool storage: record memory and first-child link memory.
module pct_node_store (
  input  logic                            clk,
  input  logic [pct_pkg::NODE_BITS-1:0]   rec_rd_addr,
  output pct_pkg::node_rec_t              rec_rd_data,
  input  pct_pkg::rec_wr_t                rec_wr,
  input  logic [pct_pkg::NODE_BITS-1:0]   link_rd_addr,
  output logic [pct_pkg::NODE_BITS-1:0]   link_rd_data,
  input  pct_pkg::link_wr_t               link_wr
);

  pct_pkg::node_rec_t            rec_mem  [pct_pkg::NODE_COUNT];
  logic [pct_pkg::NODE_BITS-1:0] link_mem [pct_pkg::NODE_COUNT];

  always_ff @(posedge clk) begin
    if (rec_wr.we) begin
      rec_mem[rec_wr.addr] <= rec_wr.data;
    end
    rec_rd_data <= rec_mem[rec_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_wr.we) begin
      link_mem[link_wr.addr] <= link_wr.data;
    end
    link_rd_data <= link_mem[link_rd_addr];
  end

endmodule

// File: sv/prefix_count_trie_top.sv
// Prefix-count trie: sequencer, cursor state and result registers.
//
// Usage: present cmd (0 insert, 1 query), symbol and last with start high;
// the symbol is taken at an edge where start is high and busy is low, and
// busy stays high while the symbol is processed. Strings arrive one symbol
// per transaction; the transaction with last set ends the string.
// Each string's final transaction produces one result: done pulses for one
// cycle with match_count (query answer, 0 for inserts) and status (1 when
// the node pool ran out during an insert). The receiver cannot stall; a
// result must be taken in its done cycle.
// Sequencing: an accepted symbol passes HEAD (first-child read) and LINK,
// then SCAN and CMP for each sibling visited in list order, then HIT or
// MISS and FIN; an insert that allocates a node also passes LINK_WR. A
// missing symbol visits all n siblings. busy falls on the return to IDLE,
// where the next transaction is taken. Once a query miss or a full pool
// stops the walk, later symbols of the string go straight to FIN. The walk is
// set by the single registered read port of the node memory: each sibling costs one read and one compare.
// Reset (synchronous, rst high) empties the trie with no memory sweep: it clears the root link,
// free pointer and cursor, as well as the state, running count, walk flag and result registers.
module prefix_count_trie_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic [pct_pkg::SYMBOL_BITS-1:0]   symbol,
  input  logic                              last,
  output logic                              done,
  output logic [pct_pkg::COUNT_BITS-1:0]    match_count,
  output logic                              status
);

  localparam int NB = pct_pkg::NODE_BITS;
  localparam int CB = pct_pkg::COUNT_BITS;

  typedef enum logic [3:0] {
    IDLE, HEAD, LINK, SCAN, CMP, HIT, MISS, LINK_WR, FIN
  } state_t;

  state_t                         state;
  logic                           cmd_q;
  logic                           last_q;
  logic [pct_pkg::SYMBOL_BITS-1:0] sym_q;
  logic [NB-1:0]                  cursor_node;
  logic [NB-1:0]                  node;
  logic [NB-1:0]                  head_q;
  logic [NB-1:0]                  root_first_child;
  logic [NB:0]                    next_free_node;
  logic [CB-1:0]                  running_count;
  logic                           walk_stopped;

  pct_pkg::node_rec_t rec_rd_data;
  pct_pkg::rec_wr_t   rec_wr;
  pct_pkg::link_wr_t  link_wr;
  logic [NB-1:0]      link_rd_data;
  logic [NB-1:0]      head;
  logic               pool_full;

  function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CB] ? pct_pkg::COUNT_MAX : s[CB-1:0];
  endfunction

  pct_node_store u_store (
    .clk          (clk),
    .rec_rd_addr  (node),
    .rec_rd_data  (rec_rd_data),
    .rec_wr       (rec_wr),
    .link_rd_addr (cursor_node),
    .link_rd_data (link_rd_data),
    .link_wr      (link_wr)
  );

  assign busy      = (state != IDLE);
  assign head      = (cursor_node == '0) ? root_first_child : link_rd_data;
  assign pool_full = (next_free_node == (NB+1)'(pct_pkg::NODE_COUNT));

  always_comb begin
    rec_wr  = '0;
    link_wr = '0;
    unique case (state)
      HIT: begin
        rec_wr.we            = !cmd_q;
        rec_wr.addr          = node;
        rec_wr.data          = rec_rd_data;
        rec_wr.data.pass_cnt = sat_add(rec_rd_data.pass_cnt, CB'(1));
        rec_wr.data.end_cnt  = sat_add(rec_rd_data.end_cnt, CB'(last_q));
      end
      MISS: begin
        // New node: link ahead of the old head, empty child list
        rec_wr.we            = !cmd_q && !pool_full;
        rec_wr.addr          = next_free_node[NB-1:0];
        rec_wr.data.symbol   = sym_q;
        rec_wr.data.sibling  = head_q;
        rec_wr.data.pass_cnt = CB'(1);
        rec_wr.data.end_cnt  = CB'(last_q);
        link_wr.we           = !cmd_q && !pool_full;
        link_wr.addr         = next_free_node[NB-1:0];
        link_wr.data         = '0;
      end
      LINK_WR: begin
        link_wr.we   = (cursor_node != '0);
        link_wr.addr = cursor_node;
        link_wr.data = node;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      cursor_node      <= '0;
      root_first_child <= '0;
      next_free_node   <= (NB+1)'(1);
      running_count    <= '0;
      walk_stopped     <= 1'b0;
      done             <= 1'b0;
      match_count      <= '0;
      status           <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            cmd_q  <= cmd;
            sym_q  <= symbol;
            last_q <= last;
            state  <= walk_stopped ? FIN : HEAD;
          end
        end
        HEAD: begin
          // wait for the cursor's first-child read
          state <= LINK;
        end
        LINK: begin
          head_q <= head;
          node   <= head;
          state  <= (head == '0) ? MISS : SCAN;
        end
        SCAN: begin
          state <= CMP;
        end
        CMP: begin
          priority if (rec_rd_data.symbol == sym_q) begin
            state <= HIT;
          end else if (rec_rd_data.sibling == '0) begin
            state <= MISS;
          end else begin
            node  <= rec_rd_data.sibling;
            state <= SCAN;
          end
        end
        HIT: begin
          if (cmd_q) begin
            running_count <= sat_add(running_count,
                                     last_q ? rec_rd_data.pass_cnt : rec_rd_data.end_cnt);
          end
          cursor_node <= node;
          state       <= FIN;
        end
        MISS: begin
          if (cmd_q || pool_full) begin
            walk_stopped <= 1'b1;
            state        <= FIN;
          end else begin
            node           <= next_free_node[NB-1:0];
            next_free_node <= next_free_node + (NB+1)'(1);
            state          <= LINK_WR;
          end
        end
        LINK_WR: begin
          if (cursor_node == '0) begin
            root_first_child <= node;
          end
          cursor_node <= node;
          state       <= FIN;
        end
        FIN: begin
          if (last_q) begin
            done          <= 1'b1;
            match_count   <= cmd_q ? running_count : '0;
            status        <= !cmd_q && walk_stopped;
            cursor_node   <= '0;
            running_count <= '0;
            walk_stopped  <= 1'b0;
          end
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_done_from_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == FIN && last_q))
    else $error("result strobe without a finished final symbol");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free_node <= (NB+1)'(pct_pkg::NODE_COUNT))
    else $error("free pointer ran past the pool");

  a_cursor_alloc: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cursor_node} < next_free_node)
    else $error("cursor points at an unallocated node");

  a_one_field: assert property (@(posedge clk) disable iff (rst)
    done |-> !(status && match_count != '0))
    else $error("result carries both a count and an error");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule
